// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication on every edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check an implication on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/icv_pkg.sv -----
// ----------------------------------------------------------------------------
// Converter package
// Shared constants, types and character classification functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icv_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int CW          = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    typedef enum logic [2:0] {
        C_FLUSH,
        C_OPND,
        C_OPEN,
        C_CLOSE,
        C_OPER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] ch;
        logic [1:0] rank;
    } t_tok;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] err;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPND,
        S_OPEN,
        S_CL_RD,
        S_CL_CHK,
        S_CL_X,
        S_OP_SP,
        S_OP_RD,
        S_OP_CHK,
        S_OP_X,
        S_OP_PUSH,
        S_OP_PUSH2,
        S_FL_RD,
        S_FL_CHK,
        S_FL_Z,
        S_FIN
    } t_state;

    function automatic logic [1:0] rank_of(input logic [7:0] c);
        logic [1:0] r;
        r = 2'd3;
        if (c == CH_OPEN) begin
            r = 2'd0;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r = 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic t_cls class_of(input logic [7:0] c);
        t_cls k;
        k = C_OPER;
        if (c == CH_NUL) begin
            k = C_FLUSH;
        end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h61 && c <= 8'h7A) || c == CH_DOT) begin
            k = C_OPND;
        end else if (c == CH_OPEN) begin
            k = C_OPEN;
        end else if (c == CH_CLOSE) begin
            k = C_CLOSE;
        end
        return k;
    endfunction

endpackage

// ----- rtl/icv_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/icv_front.sv -----
// ----------------------------------------------------------------------------
// Converter front end
// Accept input words, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_char_code,
    output logic          o_full,
    output logic          o_tok_valid,
    output icv_pkg::t_tok o_tok,
    input  logic          i_tok_take
);
    import icv_pkg::*;

    t_tok       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_n;
    logic       wr;
    logic       rd;
    t_tok       tok_in;

    assign o_full      = (r_n == 2'd2);
    assign o_tok_valid = (r_n != 2'd0);
    assign o_tok       = r_mem[r_rp];
    assign wr          = i_push && !o_full;
    assign rd          = i_tok_take && o_tok_valid;

    always_comb begin
        tok_in.cls  = class_of(i_char_code);
        tok_in.ch   = i_char_code;
        tok_in.rank = rank_of(i_char_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_n <= r_n + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= tok_in;
        end
    end

endmodule

// ----- rtl/icv_back.sv -----
// ----------------------------------------------------------------------------
// Converter back end
// Run the operator stack sequencer and queue the emitted words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icv_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tok_valid,
    input  icv_pkg::t_tok i_tok,
    output logic          o_tok_take,
    input  logic          i_pop,
    output logic          o_empty,
    output icv_pkg::t_res o_res
);
    import icv_pkg::*;

    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_ch, n_ch;
    logic [1:0]  r_rank, n_rank;
    logic [1:0]  r_err, n_err;
    logic [7:0]  r_hold;
    logic        r_hv;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [CW-1:0] cnt_dec;
    logic [CW:0]   cnt_p2;
    logic [7:0]    rdata;

    logic       do_emit;
    logic       do_fin;
    logic [7:0] e_ch;

    t_res       r_q [2];
    logic       r_qwp;
    logic       r_qrp;
    logic [1:0] r_qn;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    t_res       q_wdata;

    assign cnt_dec = r_cnt - CW'(1);
    assign cnt_p2  = {1'b0, r_cnt} + (CW + 1)'(2);

    icv_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(cnt_dec[AW-1:0]),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (do_emit) begin
                r_hv <= 1'b1;
            end else if (do_fin) begin
                r_hv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_rank <= n_rank;
        r_err  <= n_err;
        if (do_emit) begin
            r_hold <= e_ch;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ch       = r_ch;
        n_rank     = r_rank;
        n_err      = r_err;
        o_tok_take = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[AW-1:0];
        ram_wdata  = r_ch;
        ram_re     = 1'b0;
        do_emit    = 1'b0;
        do_fin     = 1'b0;
        e_ch       = r_ch;
        case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_tok_take = 1'b1;
                    n_ch       = i_tok.ch;
                    n_rank     = i_tok.rank;
                    n_err      = ERR_NONE;
                    case (i_tok.cls)
                        C_FLUSH: n_state = S_FL_RD;
                        C_OPND:  n_state = S_OPND;
                        C_OPEN:  n_state = S_OPEN;
                        C_CLOSE: n_state = S_CL_RD;
                        C_OPER:  n_state = S_OP_SP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_OPND: begin
                if (!q_full) begin
                    do_emit = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_OPEN: begin
                if (r_cnt < CW'(STACK_DEPTH)) begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                end else begin
                    n_err = ERR_OVERFLOW;
                end
                n_state = S_FIN;
            end
            S_CL_RD: begin
                if (r_cnt == '0) begin
                    n_err   = ERR_UNMATCHED;
                    n_state = S_FIN;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_CL_CHK;
                end
            end
            S_CL_CHK: begin
                if (rdata == CH_OPEN) begin
                    n_cnt   = cnt_dec;
                    n_state = S_FIN;
                end else if (!q_full) begin
                    n_cnt   = cnt_dec;
                    do_emit = 1'b1;
                    if (rdata == CH_SPACE) begin
                        e_ch    = rdata;
                        n_state = S_CL_RD;
                    end else begin
                        e_ch    = CH_SPACE;
                        n_state = S_CL_X;
                    end
                end
            end
            S_CL_X: begin
                if (!q_full) begin
                    do_emit = 1'b1;
                    e_ch    = rdata;
                    n_state = S_CL_RD;
                end
            end
            S_OP_SP: begin
                if (!q_full) begin
                    do_emit = 1'b1;
                    e_ch    = CH_SPACE;
                    n_state = S_OP_RD;
                end
            end
            S_OP_RD: begin
                if (r_cnt == '0) begin
                    n_state = S_OP_PUSH;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_OP_CHK;
                end
            end
            S_OP_CHK: begin
                if (r_rank <= rank_of(rdata)) begin
                    if (!q_full) begin
                        n_cnt   = cnt_dec;
                        do_emit = 1'b1;
                        e_ch    = CH_SPACE;
                        n_state = S_OP_X;
                    end
                end else begin
                    n_state = S_OP_PUSH;
                end
            end
            S_OP_X: begin
                if (!q_full) begin
                    do_emit = 1'b1;
                    e_ch    = rdata;
                    n_state = S_OP_RD;
                end
            end
            S_OP_PUSH: begin
                if (cnt_p2 <= (CW + 1)'(STACK_DEPTH)) begin
                    ram_we    = 1'b1;
                    ram_wdata = CH_SPACE;
                    n_cnt     = r_cnt + CW'(1);
                    n_state   = S_OP_PUSH2;
                end else begin
                    n_err   = ERR_OVERFLOW;
                    n_state = S_FIN;
                end
            end
            S_OP_PUSH2: begin
                ram_we  = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_FIN;
            end
            S_FL_RD: begin
                if (r_cnt == '0) begin
                    n_state = S_FL_Z;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_FL_CHK;
                end
            end
            S_FL_CHK: begin
                if (!q_full) begin
                    n_cnt   = cnt_dec;
                    do_emit = 1'b1;
                    e_ch    = rdata;
                    n_state = S_FL_RD;
                end
            end
            S_FL_Z: begin
                if (!q_full) begin
                    do_emit = 1'b1;
                    e_ch    = CH_NUL;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!q_full) begin
                    do_fin  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold back one word so the last one of an input can be tagged
    always_comb begin
        q_push       = 1'b0;
        q_wdata.ch   = r_hold;
        q_wdata.last = 1'b0;
        q_wdata.err  = ERR_NONE;
        if (do_emit) begin
            q_push = r_hv;
        end else if (do_fin) begin
            q_wdata.last = 1'b1;
            q_wdata.err  = r_err;
            if (r_hv) begin
                q_push = 1'b1;
            end else if (r_err != ERR_NONE) begin
                q_push     = 1'b1;
                q_wdata.ch = CH_SPACE;
            end
        end
    end

    assign q_full  = (r_qn == 2'd2);
    assign o_empty = (r_qn == 2'd0);
    assign o_res   = r_q[r_qrp];
    assign q_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwp <= 1'b0;
            r_qrp <= 1'b0;
            r_qn  <= 2'd0;
        end else begin
            if (q_push) begin
                r_qwp <= ~r_qwp;
            end
            if (q_pop) begin
                r_qrp <= ~r_qrp;
            end
            r_qn <= r_qn + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_qwp] <= q_wdata;
        end
    end

endmodule

// ----- rtl/infix_to_postfix_converter_unit.sv -----
// ----------------------------------------------------------------------------
// Infix to postfix converter
// Shunting-yard conversion of a character stream with an operator stack.
// ----------------------------------------------------------------------------
// One character word goes in per push; zero or more postfix words come out,
// the last of them tagged by run_last and carrying any error code. A front
// end classifies characters into a two-entry queue; the back end sequencer
// runs the stack held in a registered-read RAM with one write and one read
// port and feeds a two-entry result queue. Each stacked entry popped by ')',
// an operator or a flush waits for the registered RAM read before it is
// checked or emitted. The stack needs no clearing pass after reset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module infix_to_postfix_converter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_char_code,
    output logic       o_full,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic [1:0] o_error_code
);
    import icv_pkg::*;

    logic tok_valid;
    logic tok_take;
    t_tok tok;
    t_res res;
    logic res_term;

    icv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_char_code(i_char_code),
        .o_full     (o_full),
        .o_tok_valid(tok_valid),
        .o_tok      (tok),
        .i_tok_take (tok_take)
    );

    icv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok_valid(tok_valid),
        .i_tok      (tok),
        .o_tok_take (tok_take),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_res      (res)
    );

    assign o_out_char   = res.ch;
    assign o_run_last   = res.last;
    assign o_error_code = res.err;
    assign res_term     = !o_empty && (o_out_char == CH_NUL);

    `ASSERT_PROP(a_err_on_last, i_clk, i_rst_n, (!o_empty && o_error_code != ERR_NONE) |-> o_run_last)
    `ASSERT_PROP(a_err_legal, i_clk, i_rst_n, !o_empty |-> (o_error_code <= ERR_UNMATCHED))
    `ASSERT_PROP(a_term_last, i_clk, i_rst_n, res_term |-> (o_run_last && o_error_code == ERR_NONE))
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> o_empty)

endmodule

// ----- test/postfix_stream_checker.sv -----
// ----------------------------------------------------------------------------
// Postfix stream checker
// Watches the character and result channels of the converter, keeps its own
// operator stack to predict the postfix words each accepted character causes,
// and compares every popped word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_char_code,
    input  logic       i_full,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_out_char,
    input  logic       i_run_last,
    input  logic [1:0] i_error_code,
    output int         o_fail_count,
    output int         o_pending
);
    import icv_pkg::*;

    logic [7:0] op_stack [STACK_DEPTH];
    int         stack_fill = 0;
    t_res       words_due [$];
    int         due_total  = 0;
    int         fail_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_total;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        if (c == CH_OPEN) begin
            return 2'd0;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            return 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
            return 2'd2;
        end
        return 2'd3;
    endfunction

    function automatic logic operand_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == CH_DOT;
    endfunction

    function automatic t_res word_of(input logic [7:0] c);
        t_res w;
        w.ch   = c;
        w.last = 1'b0;
        w.err  = ERR_NONE;
        return w;
    endfunction

    task automatic convert_char(input logic [7:0] c);
        t_res       run_buf [$];
        t_res       tail;
        logic [1:0] err;
        logic [1:0] rank;
        logic [7:0] top_ch;
        logic       matched;
        err     = ERR_NONE;
        matched = 1'b0;
        rank    = prec_of(c);
        if (c == CH_NUL) begin
            while (stack_fill > 0) begin
                stack_fill--;
                run_buf.push_back(word_of(op_stack[stack_fill]));
            end
            run_buf.push_back(word_of(CH_NUL));
        end else if (operand_char(c)) begin
            run_buf.push_back(word_of(c));
        end else if (c == CH_OPEN) begin
            if (stack_fill < STACK_DEPTH) begin
                op_stack[stack_fill] = c;
                stack_fill++;
            end else begin
                err = ERR_OVERFLOW;
            end
        end else if (c == CH_CLOSE) begin
            while (stack_fill > 0 && !matched) begin
                stack_fill--;
                top_ch = op_stack[stack_fill];
                if (top_ch == CH_OPEN) begin
                    matched = 1'b1;
                end else begin
                    if (top_ch != CH_SPACE) begin
                        run_buf.push_back(word_of(CH_SPACE));
                    end
                    run_buf.push_back(word_of(top_ch));
                end
            end
            if (!matched) begin
                err = ERR_UNMATCHED;
            end
        end else begin
            run_buf.push_back(word_of(CH_SPACE));
            while (stack_fill > 0 && rank <= prec_of(op_stack[stack_fill - 1])) begin
                stack_fill--;
                run_buf.push_back(word_of(CH_SPACE));
                run_buf.push_back(word_of(op_stack[stack_fill]));
            end
            if (stack_fill + 2 <= STACK_DEPTH) begin
                op_stack[stack_fill]     = CH_SPACE;
                op_stack[stack_fill + 1] = c;
                stack_fill += 2;
            end else begin
                err = ERR_OVERFLOW;
            end
        end
        if (err != ERR_NONE && run_buf.size() == 0) begin
            run_buf.push_back(word_of(CH_SPACE));
        end
        if (run_buf.size() > 0) begin
            tail      = run_buf.pop_back();
            tail.last = 1'b1;
            tail.err  = err;
            run_buf.push_back(tail);
        end
        foreach (run_buf[k]) begin
            words_due.push_back(run_buf[k]);
        end
        due_total = words_due.size();
    endtask

    task automatic check_word();
        t_res want;
        if (words_due.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual %h/%b/%0d",
                     $time, i_out_char, i_run_last, i_error_code);
            fail_total++;
        end else begin
            want      = words_due.pop_front();
            due_total = words_due.size();
            if (want.ch != i_out_char) begin
                $display("%0t: out_char mismatch: expected %h, actual %h",
                         $time, want.ch, i_out_char);
                fail_total++;
            end
            if (want.last != i_run_last) begin
                $display("%0t: run_last mismatch: expected %b, actual %b",
                         $time, want.last, i_run_last);
                fail_total++;
            end
            if (want.err != i_error_code) begin
                $display("%0t: error_code mismatch: expected %0d, actual %0d",
                         $time, want.err, i_error_code);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_fill = 0;
            words_due.delete();
            due_total = 0;
        end else begin
            if (i_pop && !i_empty) begin
                check_word();
            end
            if (i_push && !i_full) begin
                convert_char(i_char_code);
            end
        end
    end

endmodule

// ----- test/infix_to_postfix_converter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Infix to postfix converter testbench
// Drives directed and random character streams into the converter, pops the
// postfix words with random stalls and leaves checking to the stream checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;

    import icv_pkg::*;

    localparam logic [7:0] CH_CARET = 8'h5E;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_char;
    logic       run_last;
    logic [1:0] error_code;
    int         fail_count;
    int         words_pending;

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         items_sent    = 0;
    int         send_idle [3] = '{11, 47, 0};
    int         recv_idle [3] = '{47, 11, 0};

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    infix_to_postfix_converter_unit u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_char_code  (char_code),
        .o_full       (full),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_out_char   (out_char),
        .o_run_last   (run_last),
        .o_error_code (error_code)
    );

    postfix_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_char_code  (char_code),
        .i_full       (full),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_char   (out_char),
        .i_run_last   (run_last),
        .i_error_code (error_code),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_char(input logic [7:0] c);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        push      <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_expression();
        int         depth;
        int         terms;
        int         open_pct;
        int         k;
        logic       broken;
        logic [7:0] c;
        depth    = 0;
        terms    = $urandom_range(1, 8);
        open_pct = ($urandom_range(9) == 0) ? 70 : 20;
        broken   = ($urandom_range(9) == 0);
        for (k = 0; k < terms; k++) begin
            while (depth < 24 && $urandom_range(99) < open_pct) begin
                send_char(CH_OPEN);
                depth++;
            end
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(3))
                    0: c = 8'("0" + $urandom_range(9));
                    1: c = 8'("A" + $urandom_range(25));
                    2: c = 8'("a" + $urandom_range(25));
                    default: c = CH_DOT;
                endcase
                send_char(c);
            end
            while (depth > 0 && $urandom_range(99) < 30) begin
                send_char(CH_CLOSE);
                depth--;
            end
            if (broken && $urandom_range(3) == 0) begin
                send_char(CH_CLOSE);
            end
            if (k < terms - 1) begin
                case ($urandom_range(8))
                    0: c = CH_PLUS;
                    1: c = CH_MINUS;
                    2: c = CH_STAR;
                    3: c = CH_SLASH;
                    4: c = CH_PCT;
                    5: c = CH_SPACE;
                    6: c = CH_CARET;
                    default: c = 8'($urandom_range(128, 255));
                endcase
                send_char(c);
            end
        end
        while (!broken && depth > 0) begin
            send_char(CH_CLOSE);
            depth--;
        end
        send_char(CH_NUL);
    endtask

    initial begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unmatched close on an empty stack, then fill the stack to overflow
        send_char(CH_CLOSE);
        repeat (5) begin
            send_char(CH_OPEN);
            send_char(CH_PLUS);
        end
        send_char(CH_STAR);
        send_char(CH_OPEN);
        send_char(CH_OPEN);
        send_char(CH_CLOSE);
        send_char(CH_NUL);
        send_char("0");
        send_char(CH_MINUS);
        send_char("9");
        send_char(CH_SLASH);
        send_char("A");
        send_char(CH_PCT);
        send_char("z");
        send_char(8'hFF);
        send_char(CH_DOT);
        send_char(CH_CLOSE);
        send_char(CH_NUL);

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = send_idle[phase];
            recv_idle_pct = recv_idle[phase];
            while (items_sent < (phase + 1) * 157) begin
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
                end else begin
                    send_expression();
                end
            end
        end

        push <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
